// File: src/lspg_pkg.sv
`timescale 1ns / 1ps
// Shared types, register codes and the color wheel for the LED strip pattern generator.
// Has no dependencies; every other file imports it.
package lspg_pkg;

  // Default strip length.
  localparam int unsigned STRIP_LEN_DEFAULT = 300;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_COLOR_ONE   = 2'd1;
  localparam logic [1:0] REG_ANIM_DELAY  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [23:0] COLOR_ONE_RESET  = 24'hFF0000;
  localparam logic [15:0] ANIM_DELAY_RESET = 16'd250;

  // Animation modes. The unused code renders as random swipe.
  typedef enum logic [2:0] {
    MODE_SOLID         = 3'd0,
    MODE_SWIPE         = 3'd1,
    MODE_RAINBOW_CYCLE = 3'd2,
    MODE_RAINBOW       = 3'd3,
    MODE_CHASE_RAINBOW = 3'd4,
    MODE_CHASE         = 3'd5,
    MODE_RANDOM_SWIPE  = 3'd6
  } mode_e;

  // What the write sweep of the pixel store is doing.
  typedef enum logic [1:0] {
    SWEEP_INIT  = 2'd0,
    SWEEP_CLEAR = 2'd1,
    SWEEP_DRAW  = 2'd2
  } sweep_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT    = 3'd0,
    ST_IDLE    = 3'd1,
    ST_DECIDE  = 3'd2,
    ST_CLEAR   = 3'd3,
    ST_DRAW    = 3'd4,
    ST_RESPOND = 3'd5
  } state_e;

  // Input item.
  typedef struct packed {
    logic        cmd;
    logic [8:0]  pixel_index;
    logic [23:0] random_color;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [23:0] pixel_color;
    logic        frame_rendered;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   accept;
    logic   read_en;
    logic   sweep_start;
    sweep_e sweep_kind;
    logic   sweep_step;
    logic   out_load;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic frame;
    logic clear_pending;
    logic sweep_last;
    logic out_free;
  } stat_t;

  // 256-step color wheel, packed red, green, blue.
  function automatic logic [23:0] wheel(input logic [7:0] pos);
    logic [7:0] w;
    logic [7:0] t;
    logic [23:0] rgb;
    w = 8'd255 - pos;
    if (w < 8'd85) begin
      t   = w + {w[6:0], 1'b0};
      rgb = {8'd255 - t, 8'd0, t};
    end else if (w < 8'd170) begin
      w   = w - 8'd85;
      t   = w + {w[6:0], 1'b0};
      rgb = {8'd0, t, 8'd255 - t};
    end else begin
      w   = w - 8'd170;
      t   = w + {w[6:0], 1'b0};
      rgb = {t, 8'd255 - t, 8'd0};
    end
    return rgb;
  endfunction

endpackage

// File: src/led_strip_pattern_generator.sv
`timescale 1ns / 1ps
// Top level of the LED strip pattern generator: joins the controller and the datapath.
// Depends on lspg_pkg, lspg_ctrl and lspg_datapath.

// Seven-mode LED strip animation engine. Each tick item advances a millisecond
// counter; once it exceeds animation_delay the tick renders one frame into an
// internal pixel store, and each read item returns one stored pixel. After reset
// the store is cleared by a write pass over every pixel during which no item is
// taken; configuration writes are taken at any time. A read or a tick that
// renders nothing goes from the decide state to the respond state, where its
// result loads into the output register once that register is free; the next
// item can transfer when the controller is back in idle. A rendering tick adds
// one write sweep of the store, one pixel per cycle: every pixel for solid and
// rainbow frames, every third pixel for theater chase frames and one pixel for
// swipe frames, plus a sweep over every third pixel when the lit pixels of a
// previous chase frame are cleared first. The block works on one item at a time,
// and a finished result waits in an output register while the next item enters.
module led_strip_pattern_generator import lspg_pkg::*; #(
  parameter int unsigned STRIP_LEN = STRIP_LEN_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer.
  lspg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // Registers, pixel store and result path.
  lspg_datapath #(
    .STRIP_LEN (STRIP_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

// File: src/lspg_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the LED strip pattern generator.
// Depends on lspg_pkg for the state, command and status types.
module lspg_ctrl import lspg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (stat_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat_i.is_read || !stat_i.frame) begin
          state_d = ST_RESPOND;
        end else if (stat_i.clear_pending) begin
          state_d = ST_CLEAR;
        end else begin
          state_d = ST_DRAW;
        end
      end
      ST_CLEAR: begin
        if (stat_i.sweep_last) state_d = ST_DRAW;
      end
      ST_DRAW: begin
        if (stat_i.sweep_last) state_d = ST_RESPOND;
      end
      ST_RESPOND: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Command outputs.
  always_comb begin
    ctrl_o            = '0;
    ctrl_o.sweep_kind = SWEEP_DRAW;
    in_stall_o        = 1'b1;
    unique case (state_q)
      ST_INIT: begin
        ctrl_o.sweep_step = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        ctrl_o.accept = in_valid_i;
      end
      ST_DECIDE: begin
        if (stat_i.is_read) begin
          ctrl_o.read_en = 1'b1;
        end else if (stat_i.frame) begin
          ctrl_o.sweep_start = 1'b1;
          ctrl_o.sweep_kind  = stat_i.clear_pending ? SWEEP_CLEAR : SWEEP_DRAW;
        end
      end
      ST_CLEAR: begin
        ctrl_o.sweep_step = 1'b1;
        // The draw sweep starts as soon as the last cleared pixel is written.
        if (stat_i.sweep_last) begin
          ctrl_o.sweep_start = 1'b1;
          ctrl_o.sweep_kind  = SWEEP_DRAW;
        end
      end
      ST_DRAW: begin
        ctrl_o.sweep_step = 1'b1;
      end
      ST_RESPOND: begin
        ctrl_o.out_load = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: src/lspg_datapath.sv
`timescale 1ns / 1ps
// Datapath of the LED strip pattern generator: configuration registers, animation
// counters, pixel store, write sweep and output register. Depends on lspg_pkg.
module lspg_datapath import lspg_pkg::*; #(
  parameter int unsigned STRIP_LEN = STRIP_LEN_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_wdata_i,
  input  in_item_t  in_data_i,
  output out_item_t out_data_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ctrl_t     ctrl_i,
  output stat_t     stat_o
);

  localparam int unsigned AW = $clog2(STRIP_LEN);
  localparam int unsigned CW = $clog2(STRIP_LEN + 3);
  localparam int unsigned RW = $clog2(2 * STRIP_LEN);
  localparam logic [CW-1:0] N_C        = CW'(STRIP_LEN);
  localparam logic [AW-1:0] LAST_POS   = AW'(STRIP_LEN - 1);
  localparam logic [RW-1:0] N_R        = RW'(STRIP_LEN);
  localparam logic [7:0]    HUE_STEP   = 8'(256 / STRIP_LEN);
  localparam logic [RW-1:0] HUE_REM    = RW'(256 % STRIP_LEN);

  // Configuration registers.
  mode_e       mode_q;
  logic [23:0] color_q;
  logic [15:0] delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SOLID;
      color_q <= COLOR_ONE_RESET;
      delay_q <= ANIM_DELAY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE:       mode_q  <= mode_e'(cfg_wdata_i[2:0]);
        REG_COLOR_ONE:  color_q <= cfg_wdata_i;
        REG_ANIM_DELAY: delay_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Captured input item.
  logic        cmd_q;
  logic [8:0]  idx_q;
  logic [23:0] rnd_q;
  logic        in_range_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q      <= in_data_i.cmd;
      idx_q      <= in_data_i.pixel_index;
      rnd_q      <= in_data_i.random_color;
      in_range_q <= 32'(in_data_i.pixel_index) < 32'(STRIP_LEN);
    end
  end

  // Millisecond counter, saturating; a tick that passes the delay renders a frame.
  logic [15:0] elapsed_q;
  logic [15:0] elapsed_inc;
  logic        frame_now;
  logic        frame_q;

  assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
  assign frame_now   = elapsed_inc > delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      frame_q   <= 1'b0;
    end else if (ctrl_i.accept) begin
      frame_q <= !in_data_i.cmd && frame_now;
      if (!in_data_i.cmd) elapsed_q <= frame_now ? 16'd0 : elapsed_inc;
    end
  end

  // Sweep counter and per-frame color counters.
  sweep_e        kind_q;
  logic [CW-1:0] i_q;
  logic [7:0]    hue_q;
  logic [RW-1:0] rem_q;
  logic [7:0]    chase_hue_q;

  // Animation state.
  logic [AW-1:0] swipe_pos_q;
  logic [AW-1:0] rnd_pos_q;
  logic [7:0]    cycle_off_q;
  logic [7:0]    cr_off_q;
  logic [1:0]    cr_phase_q;
  logic [1:0]    chase_phase_q;
  logic          clear_pending_q;
  logic [1:0]    clear_phase_q;

  // Write address, data and step of the current sweep cycle.
  logic [1:0]    base;
  logic          step3;
  logic          single;
  logic [AW-1:0] single_pos;
  logic [23:0]   wdata;
  logic [CW-1:0] step_c;
  logic [CW-1:0] addr_c;
  logic          mem_we;
  logic          sweep_last;

  always_comb begin
    base       = 2'd0;
    step3      = 1'b0;
    single     = 1'b0;
    single_pos = swipe_pos_q;
    wdata      = 24'd0;
    unique case (kind_q)
      SWEEP_INIT: ;
      SWEEP_CLEAR: begin
        base  = clear_phase_q;
        step3 = 1'b1;
      end
      SWEEP_DRAW: begin
        unique case (mode_q)
          MODE_SOLID: wdata = color_q;
          MODE_SWIPE: begin
            single = 1'b1;
            wdata  = color_q;
          end
          MODE_RAINBOW_CYCLE: wdata = wheel(hue_q + cycle_off_q);
          MODE_RAINBOW:       wdata = wheel(hue_q);
          MODE_CHASE_RAINBOW: begin
            base  = cr_phase_q;
            step3 = 1'b1;
            wdata = wheel(chase_hue_q);
          end
          MODE_CHASE: begin
            base  = chase_phase_q;
            step3 = 1'b1;
            wdata = color_q;
          end
          default: begin
            single     = 1'b1;
            single_pos = rnd_pos_q;
            wdata      = rnd_q;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign step_c     = step3 ? CW'(3) : CW'(1);
  assign addr_c     = single ? CW'(single_pos) : i_q + CW'(base);
  assign mem_we     = ctrl_i.sweep_step && (addr_c < N_C);
  assign sweep_last = single || ((i_q + step_c) >= N_C);

  // Hue of pixel i is floor(i * 256 / STRIP_LEN), kept as quotient and remainder.
  logic [RW-1:0] rem_sum;
  logic [8:0]    chase_sum;

  assign rem_sum   = rem_q + HUE_REM;
  assign chase_sum = {1'b0, chase_hue_q} + 9'd3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= SWEEP_INIT;
      i_q         <= '0;
      hue_q       <= '0;
      rem_q       <= '0;
      chase_hue_q <= '0;
    end else if (ctrl_i.sweep_start) begin
      kind_q      <= ctrl_i.sweep_kind;
      i_q         <= '0;
      hue_q       <= '0;
      rem_q       <= '0;
      chase_hue_q <= (cr_off_q == 8'd255) ? 8'd0 : cr_off_q;
    end else if (ctrl_i.sweep_step) begin
      i_q <= i_q + step_c;
      if (rem_sum >= N_R) begin
        hue_q <= hue_q + HUE_STEP + 8'd1;
        rem_q <= rem_sum - N_R;
      end else begin
        hue_q <= hue_q + HUE_STEP;
        rem_q <= rem_sum;
      end
      chase_hue_q <= (chase_sum >= 9'd255) ? 8'(chase_sum - 9'd255) : chase_sum[7:0];
    end
  end

  // Counter updates at the end of a clear or draw sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swipe_pos_q     <= '0;
      rnd_pos_q       <= '0;
      cycle_off_q     <= '0;
      cr_off_q        <= '0;
      cr_phase_q      <= '0;
      chase_phase_q   <= '0;
      clear_pending_q <= 1'b0;
      clear_phase_q   <= '0;
    end else if (ctrl_i.sweep_step && sweep_last) begin
      if (kind_q == SWEEP_CLEAR) begin
        clear_pending_q <= 1'b0;
      end else if (kind_q == SWEEP_DRAW) begin
        unique case (mode_q) inside
          MODE_SOLID, MODE_RAINBOW: ;
          MODE_SWIPE: begin
            swipe_pos_q <= (swipe_pos_q == LAST_POS) ? '0 : swipe_pos_q + AW'(1);
          end
          MODE_RAINBOW_CYCLE: cycle_off_q <= cycle_off_q + 8'd1;
          MODE_CHASE_RAINBOW: begin
            clear_pending_q <= 1'b1;
            clear_phase_q   <= cr_phase_q;
            cr_phase_q      <= (cr_phase_q == 2'd2) ? 2'd0 : cr_phase_q + 2'd1;
            cr_off_q        <= cr_off_q + 8'd1;
          end
          MODE_CHASE: begin
            clear_pending_q <= 1'b1;
            clear_phase_q   <= chase_phase_q;
            chase_phase_q   <= (chase_phase_q == 2'd2) ? 2'd0 : chase_phase_q + 2'd1;
          end
          default: begin
            rnd_pos_q <= (rnd_pos_q == LAST_POS) ? '0 : rnd_pos_q + AW'(1);
          end
        endcase
      end
    end
  end

  // Pixel store: one write port for the sweep, one registered read port.
  logic [23:0] mem_q [STRIP_LEN];
  logic [23:0] rdata_q;
  logic [31:0] idx_ext;

  assign idx_ext = 32'(idx_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[addr_c[AW-1:0]] <= wdata;
    if (ctrl_i.read_en) rdata_q <= mem_q[idx_ext[AW-1:0]];
  end

  // Output register; a new result loads when the slot is empty or being taken.
  logic      out_valid_q;
  out_item_t out_q;
  logic      out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_q.pixel_color    <= (cmd_q && in_range_q) ? rdata_q : 24'd0;
      out_q.frame_rendered <= frame_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the controller.
  assign stat_o.is_read       = cmd_q;
  assign stat_o.frame         = frame_q;
  assign stat_o.clear_pending = clear_pending_q;
  assign stat_o.sweep_last    = sweep_last;
  assign stat_o.out_free      = out_free;

endmodule

// File: bench/tb_led_strip_pattern_generator.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_strip_pattern_generator: a frame store model
// predicts every result, and random traffic with stalls exercises all modes.
// Depends on lspg_pkg and the led_strip_pattern_generator RTL.

import lspg_pkg::*;

// Tracks the expected strip contents and compares each result with its prediction.
class strip_scoreboard;
  logic [23:0] frame_px [STRIP_LEN_DEFAULT];
  int unsigned elapsed_ms;
  int unsigned swipe_pos;
  int unsigned rnd_swipe_pos;
  int unsigned cycle_ofs;
  int unsigned chase_rb_ofs;
  int unsigned chase_rb_phase;
  int unsigned chase_phase;
  bit          clear_pending;
  int unsigned clear_phase;
  logic [2:0]  mode;
  logic [23:0] color_one;
  logic [15:0] anim_delay;
  out_item_t   expected_q [$];
  int          errors;

  function new();
    for (int i = 0; i < STRIP_LEN_DEFAULT; i++) frame_px[i] = '0;
    elapsed_ms     = 0;
    swipe_pos      = 0;
    rnd_swipe_pos  = 0;
    cycle_ofs      = 0;
    chase_rb_ofs   = 0;
    chase_rb_phase = 0;
    chase_phase    = 0;
    clear_pending  = 1'b0;
    clear_phase    = 0;
    mode           = MODE_SOLID;
    color_one      = COLOR_ONE_RESET;
    anim_delay     = ANIM_DELAY_RESET;
    errors         = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void set_reg(logic [1:0] idx, logic [23:0] val);
    case (idx)
      REG_MODE:       mode = val[2:0];
      REG_COLOR_ONE:  color_one = val;
      REG_ANIM_DELAY: anim_delay = val[15:0];
      default: ;
    endcase
  endfunction

  // Wheel position to packed color: three ramps of 85 steps each.
  function logic [23:0] color_wheel(int unsigned pos);
    int unsigned w;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    w = 255 - (pos & 255);
    if (w < 85) begin
      r = 8'(255 - 3 * w);
      g = 8'd0;
      b = 8'(3 * w);
    end else if (w < 170) begin
      w = w - 85;
      r = 8'd0;
      g = 8'(3 * w);
      b = 8'(255 - 3 * w);
    end else begin
      w = w - 170;
      r = 8'(3 * w);
      g = 8'(255 - 3 * w);
      b = 8'd0;
    end
    return {r, g, b};
  endfunction

  function void put_px(int unsigned idx, logic [23:0] color);
    if (idx < STRIP_LEN_DEFAULT) frame_px[idx] = color;
  endfunction

  // One frame: first the deferred clear of the last theater frame, then the mode.
  function void render(logic [23:0] rnd_color);
    if (clear_pending) begin
      for (int unsigned i = 0; i < STRIP_LEN_DEFAULT; i += 3) put_px(i + clear_phase, '0);
      clear_pending = 1'b0;
    end
    case (mode)
      MODE_SOLID: begin
        for (int unsigned i = 0; i < STRIP_LEN_DEFAULT; i++) frame_px[i] = color_one;
      end
      MODE_SWIPE: begin
        put_px(swipe_pos, color_one);
        swipe_pos = (swipe_pos + 1) % STRIP_LEN_DEFAULT;
      end
      MODE_RAINBOW_CYCLE: begin
        for (int unsigned i = 0; i < STRIP_LEN_DEFAULT; i++)
          frame_px[i] = color_wheel((i * 256 / STRIP_LEN_DEFAULT + cycle_ofs) & 255);
        cycle_ofs = (cycle_ofs + 1) & 255;
      end
      MODE_RAINBOW: begin
        for (int unsigned i = 0; i < STRIP_LEN_DEFAULT; i++)
          frame_px[i] = color_wheel(i * 256 / STRIP_LEN_DEFAULT);
      end
      MODE_CHASE_RAINBOW: begin
        for (int unsigned i = 0; i < STRIP_LEN_DEFAULT; i += 3)
          put_px(i + chase_rb_phase, color_wheel((i + chase_rb_ofs) % 255));
        clear_pending  = 1'b1;
        clear_phase    = chase_rb_phase;
        chase_rb_phase = (chase_rb_phase + 1) % 3;
        chase_rb_ofs   = (chase_rb_ofs + 1) & 255;
      end
      MODE_CHASE: begin
        for (int unsigned i = 0; i < STRIP_LEN_DEFAULT; i += 3)
          put_px(i + chase_phase, color_one);
        clear_pending = 1'b1;
        clear_phase   = chase_phase;
        chase_phase   = (chase_phase + 1) % 3;
      end
      // Random swipe, and the unused code that behaves the same way.
      default: begin
        put_px(rnd_swipe_pos, rnd_color);
        rnd_swipe_pos = (rnd_swipe_pos + 1) % STRIP_LEN_DEFAULT;
      end
    endcase
  endfunction

  // Called for every accepted input transfer.
  function void note_input(in_item_t it);
    out_item_t exp_r;
    exp_r = '0;
    if (it.cmd) begin
      if (it.pixel_index < STRIP_LEN_DEFAULT) exp_r.pixel_color = frame_px[it.pixel_index];
    end else begin
      if (elapsed_ms < 65535) elapsed_ms++;
      if (elapsed_ms > anim_delay) begin
        elapsed_ms = 0;
        render(it.random_color);
        exp_r.frame_rendered = 1'b1;
      end
    end
    expected_q.push_back(exp_r);
  endfunction

  task report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    if (errors < 100) $display("MISMATCH %s: got %h, want %h", what, got, want);
    errors++;
  endtask

  // Called for every accepted output transfer.
  task check_result(out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected result", got.pixel_color, '0);
      return;
    end
    want = expected_q.pop_front();
    if (got.pixel_color !== want.pixel_color)
      report_mismatch("pixel_color", got.pixel_color, want.pixel_color);
    if (got.frame_rendered !== want.frame_rendered)
      report_mismatch("frame_rendered", {23'd0, got.frame_rendered},
                      {23'd0, want.frame_rendered});
  endtask
endclass

module tb_led_strip_pattern_generator;

  localparam logic       CMD_TICK    = 1'b0;
  localparam logic       CMD_READ    = 1'b1;
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int unsigned IDLE_PCT    = 32;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_TICKS  = 40;
  localparam int unsigned PHASES      = 18;
  localparam int unsigned PHASE_ITEMS = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;

  strip_scoreboard sb;
  bit          calm;
  int unsigned hold_reqs;
  int unsigned holds_done;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  led_strip_pattern_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offer one item, with random idle cycles first, and wait for its transfer.
  task automatic send_item(input logic cmd, input logic [8:0] idx, input logic [23:0] rnd);
    in_item_t it;
    it.cmd          = cmd;
    it.pixel_index  = idx;
    it.random_color = rnd;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_input(it);
  endtask

  // Stop offering items until every predicted result has come back.
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all three registers, one per cycle, while the block is idle.
  task automatic program_regs(input logic [2:0] m, input logic [23:0] color,
                              input logic [15:0] delay);
    logic [1:0]  regs [3];
    logic [23:0] vals [3];
    regs    = '{REG_MODE, REG_COLOR_ONE, REG_ANIM_DELAY};
    vals[0] = {21'd0, m};
    vals[1] = color;
    vals[2] = {8'd0, delay};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Result side: check each transfer, then pick the stall for the next cycle.
  initial begin
    out_stall_i = 1'b0;
    hold_left   = 0;
    holds_done  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) sb.check_result(out_data_o);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (holds_done != hold_reqs) begin
        holds_done++;
        hold_left   = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog: too long without any transfer means the block has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus: directed checks, random phases, then a delay that never expires.
  initial begin
    logic [2:0]  dir_modes [8];
    logic [2:0]  m;
    logic [23:0] color;
    logic [15:0] delay;
    dir_modes    = '{MODE_SOLID, MODE_SWIPE, MODE_RAINBOW_CYCLE, MODE_RAINBOW,
                     MODE_CHASE_RAINBOW, MODE_CHASE, MODE_RANDOM_SWIPE, MODE_UNUSED};
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = REG_MODE;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    calm         = 1'b0;
    hold_reqs    = 0;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The store is cleared by reset; the top index is out of range.
    send_item(CMD_READ, 9'd0, 24'hFFFFFF);
    send_item(CMD_READ, 9'h1FF, 24'hFFFFFF);

    // Every mode, with the unused code last, rendering on each tick.
    for (int k = 0; k < 8; k++) begin
      wait_results_done();
      program_regs(dir_modes[k], (k % 2 == 0) ? 24'hFFFFFF : 24'h000000, 16'd0);
      send_item(CMD_TICK, 9'd0, (k % 2 == 0) ? 24'h000000 : 24'hFFFFFF);
      send_item(CMD_READ, 9'd0, 24'h000000);
      send_item(CMD_READ, 9'd299, 24'h000000);
    end

    // Random phases: one without any idling, one with a long result hold-off.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_results_done();
      calm = (ph == 3);
      m = 3'($urandom_range(7));
      case ($urandom_range(7))
        0:       color = 24'hFFFFFF;
        1:       color = 24'h000000;
        default: color = 24'($urandom);
      endcase
      case ($urandom_range(9))
        0, 1, 2: delay = 16'd0;
        3, 4, 5: delay = 16'd1;
        6, 7:    delay = 16'($urandom_range(5, 2));
        8:       delay = 16'($urandom_range(40, 6));
        default: delay = ANIM_DELAY_RESET;
      endcase
      program_regs(m, color, delay);
      if (ph == 6) hold_reqs++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 55)
          send_item(CMD_TICK, 9'($urandom), 24'($urandom));
        else if ($urandom_range(99) < 85)
          send_item(CMD_READ, 9'($urandom_range(299)), 24'($urandom));
        else
          send_item(CMD_READ, 9'($urandom_range(511, 300)), 24'($urandom));
      end
    end

    // A delay of all ones holds off rendering; a short delay then renders at once.
    wait_results_done();
    calm = 1'b1;
    program_regs(MODE_SOLID, 24'h123456, 16'hFFFF);
    for (int unsigned n = 0; n < LONG_TICKS; n++)
      send_item(CMD_TICK, 9'($urandom), 24'($urandom));
    wait_results_done();
    program_regs(MODE_SOLID, 24'h00FF00, 16'd10);
    send_item(CMD_TICK, 9'd0, 24'($urandom));
    send_item(CMD_READ, 9'd5, 24'h000000);

    wait_results_done();
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
src/lspg_pkg.sv
src/lspg_ctrl.sv
src/lspg_datapath.sv
src/led_strip_pattern_generator.sv
bench/tb_led_strip_pattern_generator.sv
